FILE: hdl/iso_cp_pkg.sv
`timescale 1ns / 1ps

package iso_cp_pkg;

   // Where the parser stands within the coordinate string.
   typedef enum logic [1:0] {
      PART_LAT_SIGN   = 2'd0,
      PART_LAT_DIGITS = 2'd1,
      PART_LON_DIGITS = 2'd2,
      PART_UNUSED     = 2'd3
   } part_type;

   localparam logic [7:0] ASCII_PLUS  = 8'h2B;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;

   localparam logic [2:0] LAT_DEG_DIGITS = 3'd2;
   localparam logic [2:0] LON_DEG_DIGITS = 3'd3;
   localparam logic [2:0] LAT_MAX_DIGITS = 3'd6;
   localparam logic [2:0] LON_MAX_DIGITS = 3'd7;

   localparam logic [21:0] SEC_PER_DEG = 22'd3600;
   localparam logic [21:0] SEC_PER_MIN = 22'd60;

   // Everything the conversion stage needs once the final character is in.
   typedef struct packed {
      logic        ok;
      logic        lat_negative;
      logic        lon_negative;
      logic [18:0] lat_magnitude;
      logic [9:0]  degree;
      logic [6:0]  minute;
      logic [6:0]  second;
   } snapshot_type;

   // deg*3600 + min*60 + sec; the result never exceeds 22 bits.
   function automatic logic [21:0] group_arcsec(input logic [9:0] degree,
                                                input logic [6:0] minute,
                                                input logic [6:0] second);
      logic [21:0] sum;
      sum = 22'(degree) * SEC_PER_DEG + 22'(minute) * SEC_PER_MIN + 22'(second);
      return sum;
   endfunction

endpackage

FILE: hdl/iso_cp_scan.sv
`timescale 1ns / 1ps

module iso_cp_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              character,
   input  logic                    last,
   output iso_cp_pkg::snapshot_type snapshot
);

   iso_cp_pkg::part_type part_ff, part_in;
   logic [2:0]  digit_count_ff, digit_count_in;
   logic        lat_negative_ff, lat_negative_in;
   logic        lon_negative_ff, lon_negative_in;
   logic [9:0]  degree_ff, degree_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic [18:0] lat_magnitude_ff, lat_magnitude_in;
   logic        error_ff, error_in;

   logic        is_sign;
   logic        is_digit;
   logic [3:0]  digit_value;
   logic [2:0]  deg_digits;
   logic [2:0]  max_digits;
   logic [21:0] lat_arcsec;

   assign is_sign     = (character == iso_cp_pkg::ASCII_PLUS) ||
                        (character == iso_cp_pkg::ASCII_MINUS);
   assign is_digit    = (character >= iso_cp_pkg::ASCII_ZERO) &&
                        (character <= iso_cp_pkg::ASCII_NINE);
   assign digit_value = character[3:0];
   assign lat_arcsec  = iso_cp_pkg::group_arcsec(degree_ff, minute_ff, second_ff);

   always_comb begin
      if (part_ff == iso_cp_pkg::PART_LON_DIGITS) begin
         deg_digits = iso_cp_pkg::LON_DEG_DIGITS;
         max_digits = iso_cp_pkg::LON_MAX_DIGITS;
      end else begin
         deg_digits = iso_cp_pkg::LAT_DEG_DIGITS;
         max_digits = iso_cp_pkg::LAT_MAX_DIGITS;
      end
   end

   // Next part of the string.
   always_comb begin
      part_in = part_ff;
      if (!error_ff) begin
         unique case (part_ff)
            iso_cp_pkg::PART_LAT_SIGN:   part_in = iso_cp_pkg::PART_LAT_DIGITS;
            iso_cp_pkg::PART_LAT_DIGITS: begin
               if (is_sign) begin
                  part_in = iso_cp_pkg::PART_LON_DIGITS;
               end
            end
            iso_cp_pkg::PART_LON_DIGITS: part_in = part_ff;
            iso_cp_pkg::PART_UNUSED:     part_in = part_ff;
         endcase
      end
   end

   // Sign, digit group and error updates for the current character.
   always_comb begin
      digit_count_in   = digit_count_ff;
      lat_negative_in  = lat_negative_ff;
      lon_negative_in  = lon_negative_ff;
      degree_in        = degree_ff;
      minute_in        = minute_ff;
      second_in        = second_ff;
      lat_magnitude_in = lat_magnitude_ff;
      error_in         = error_ff;
      if (!error_ff) begin
         unique case (part_ff) inside
            iso_cp_pkg::PART_LAT_SIGN: begin
               if (is_sign) begin
                  lat_negative_in = (character == iso_cp_pkg::ASCII_MINUS);
               end else begin
                  error_in = 1'b1;
               end
            end
            iso_cp_pkg::PART_LAT_DIGITS,
            iso_cp_pkg::PART_LON_DIGITS: begin
               if (is_sign && part_ff == iso_cp_pkg::PART_LAT_DIGITS) begin
                  // The latitude group closes on the longitude sign.
                  if (digit_count_ff != 3'd4 && digit_count_ff != 3'd6) begin
                     error_in = 1'b1;
                  end
                  lat_magnitude_in = lat_arcsec[18:0];
                  lon_negative_in  = (character == iso_cp_pkg::ASCII_MINUS);
                  digit_count_in   = '0;
                  degree_in        = '0;
                  minute_in        = '0;
                  second_in        = '0;
               end else if (!is_digit) begin
                  error_in = 1'b1;
               end else if (digit_count_ff >= max_digits) begin
                  error_in = 1'b1;
               end else begin
                  if (digit_count_ff < deg_digits) begin
                     degree_in = 10'({degree_ff, 3'b000} + {degree_ff, 1'b0} +
                                     13'(digit_value));
                  end else if (digit_count_ff < deg_digits + 3'd2) begin
                     minute_in = 7'({minute_ff, 3'b000} + {minute_ff, 1'b0} +
                                    10'(digit_value));
                  end else begin
                     second_in = 7'({second_ff, 3'b000} + {second_ff, 1'b0} +
                                    10'(digit_value));
                  end
                  digit_count_in = digit_count_ff + 3'd1;
               end
            end
            iso_cp_pkg::PART_UNUSED: error_in = 1'b1;
         endcase
      end
   end

   always_comb begin
      snapshot.ok            = !error_in && (part_in == iso_cp_pkg::PART_LON_DIGITS) &&
                               (digit_count_in == 3'd5 || digit_count_in == 3'd7);
      snapshot.lat_negative  = lat_negative_in;
      snapshot.lon_negative  = lon_negative_in;
      snapshot.lat_magnitude = lat_magnitude_in;
      snapshot.degree        = degree_in;
      snapshot.minute        = minute_in;
      snapshot.second        = second_in;
   end

   // The final character of a string returns the parser to its reset state.
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         part_ff          <= iso_cp_pkg::PART_LAT_SIGN;
         digit_count_ff   <= '0;
         lat_negative_ff  <= 1'b0;
         lon_negative_ff  <= 1'b0;
         degree_ff        <= '0;
         minute_ff        <= '0;
         second_ff        <= '0;
         lat_magnitude_ff <= '0;
         error_ff         <= 1'b0;
      end else if (step) begin
         part_ff          <= part_in;
         digit_count_ff   <= digit_count_in;
         lat_negative_ff  <= lat_negative_in;
         lon_negative_ff  <= lon_negative_in;
         degree_ff        <= degree_in;
         minute_ff        <= minute_in;
         second_ff        <= second_in;
         lat_magnitude_ff <= lat_magnitude_in;
         error_ff         <= error_in;
      end
   end

endmodule

FILE: hdl/iso6709_coordinate_parser_unit.sv
`timescale 1ns / 1ps
// ISO 6709 coordinate parser: one ASCII character per transaction, the last one flagged.
// Throughput: one character per clock, unless a stalled result side holds back a final one;
// nothing in the path iterates. A string's result passes from the input register through the
// parse step into the snapshot register, then through conversion into the output register.
// Reset (synchronous, active high) empties all three stages and returns the parser to
// waiting for a latitude sign; the parser also returns there after every final character.

module iso6709_coordinate_parser_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_character,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_valid_res,
   output logic signed [19:0] rsp_latitude_arcsec,
   output logic signed [22:0] rsp_longitude_arcsec
);

   // Input register stage.
   logic       in_valid_ff;
   logic [7:0] in_character_ff;
   logic       in_last_ff;

   // Snapshot of the parser after a final character.
   logic                     snap_valid_ff;
   iso_cp_pkg::snapshot_type snap_ff;
   iso_cp_pkg::snapshot_type snap_in;

   // Output register stage.
   logic               rsp_valid_ff;
   logic               rsp_valid_res_ff;
   logic signed [19:0] rsp_latitude_ff;
   logic signed [22:0] rsp_longitude_ff;

   logic        out_free;
   logic        snap_free;
   logic        step;
   logic [21:0] lon_magnitude;
   logic [19:0] lat_in;
   logic [22:0] lon_in;

   // A stage may take new data when it is empty or its content leaves this cycle.
   // Characters that are not final never reach the snapshot stage, so they move on
   // even when the result side is stalled.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign snap_free = !snap_valid_ff || out_free;
   assign step      = in_valid_ff && (!in_last_ff || snap_free);
   assign req_stall = in_valid_ff && !step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || step) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_character_ff <= req_character;
         in_last_ff      <= req_last;
      end
   end

   iso_cp_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .character (in_character_ff),
      .last      (in_last_ff),
      .snapshot  (snap_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (snap_free) begin
         snap_valid_ff <= step && in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_free && step && in_last_ff) begin
         snap_ff <= snap_in;
      end
   end

   // Conversion: longitude group to arcseconds, then apply both signs.
   // An invalid string reports zero for both angles.
   assign lon_magnitude = iso_cp_pkg::group_arcsec(snap_ff.degree, snap_ff.minute,
                                                   snap_ff.second);

   always_comb begin
      lat_in = '0;
      lon_in = '0;
      if (snap_ff.ok) begin
         lat_in = snap_ff.lat_negative ? (20'd0 - 20'(snap_ff.lat_magnitude))
                                       : 20'(snap_ff.lat_magnitude);
         lon_in = snap_ff.lon_negative ? (23'd0 - 23'(lon_magnitude))
                                       : 23'(lon_magnitude);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && snap_valid_ff) begin
         rsp_valid_res_ff <= snap_ff.ok;
         rsp_latitude_ff  <= signed'(lat_in);
         rsp_longitude_ff <= signed'(lon_in);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_valid_res        = rsp_valid_res_ff;
   assign rsp_latitude_arcsec  = rsp_latitude_ff;
   assign rsp_longitude_arcsec = rsp_longitude_ff;

endmodule
